[rtl/text_bitmap_cell_pixel_generator_top_assert.svh]
// -----------------------------------------------------------------------------
// Assertion macros for the character cell pixel generator
// Immediate-implication and next-cycle-implication checks, clocked and reset
// gated. They collapse to nothing when SYNTHESIS is defined.
// -----------------------------------------------------------------------------
`ifndef TEXT_BITMAP_CELL_PIXEL_GENERATOR_TOP_ASSERT_SVH
`define TEXT_BITMAP_CELL_PIXEL_GENERATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define TBCPG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define TBCPG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define TBCPG_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define TBCPG_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

[rtl/tbcpg_pkg.sv]
// -----------------------------------------------------------------------------
// tbcpg_pkg
// Shared types and constants of the character cell pixel generator.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tbcpg_pkg;

   localparam int PIXEL_COUNT   = 8;
   localparam int PIXEL_WIDTH   = 4;
   localparam int WORD_WIDTH    = PIXEL_COUNT * PIXEL_WIDTH;
   localparam int CODE_WIDTH    = 8;
   localparam int PATTERN_WIDTH = 8;
   localparam int REQ_WIDTH     = 24;   // 20 field bits padded to whole bytes
   localparam int CSR_IDX_WIDTH = 3;
   localparam int CSR_DAT_WIDTH = 4;

   typedef logic [PIXEL_WIDTH-1:0]   color_type;
   typedef logic [CODE_WIDTH-1:0]    code_type;
   typedef logic [PATTERN_WIDTH-1:0] pattern_type;
   typedef logic [WORD_WIDTH-1:0]    word_type;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_DISPLAY_ENABLE = 3'd0,
      CSR_EXTENDED_COLOR = 3'd1,
      CSR_BITMAP_MODE    = 3'd2,
      CSR_MULTICOLOR     = 3'd3,
      CSR_BACKGROUND_0   = 3'd4,
      CSR_BACKGROUND_1   = 3'd5,
      CSR_BACKGROUND_2   = 3'd6,
      CSR_BACKGROUND_3   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic      display_enable;
      logic      extended_color_mode;
      logic      bitmap_mode;
      logic      multicolor_mode;
      color_type background_color_0;
      color_type background_color_1;
      color_type background_color_2;
      color_type background_color_3;
   } cfg_type;

   typedef struct packed {
      code_type    screen_code;
      color_type   color_nibble;
      pattern_type pattern_byte;
   } cell_type;

endpackage

`default_nettype wire

[rtl/text_bitmap_cell_pixel_generator_top.sv]
// -----------------------------------------------------------------------------
// text_bitmap_cell_pixel_generator_top
// Turns one character cell per transaction into eight 4-bit pixel colors.
// -----------------------------------------------------------------------------
// Channel | Direction | Payload (low bit first)                     | Role
// req_*   | in        | screen_code[7:0] color_nibble[11:8]
//         |           | pattern_byte[19:12], zero pad [23:20]       | one cell
// rsp_*   | out       | pixel_word[31:0], leftmost pixel in [31:28] | pixels
// csr_*   | in        | csr_index[2:0] register, csr_data[3:0]      | config
//
// Accepting a cell loads it into the input register; its render moves into
// the result register once that register has room, and rsp_tvalid then
// rises. A new cell is accepted every cycle while rsp_tready keeps up.
// Reset is synchronous, clears both valid flags and all mode registers.
// A stalled rsp holds the result; the input register still takes one more
// cell, and only then does req_tready drop.
// With display_enable low, cells are consumed and produce no transaction.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "text_bitmap_cell_pixel_generator_top_assert.svh"

module text_bitmap_cell_pixel_generator_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // cell input
   input  wire logic                                  req_tvalid,
   output      logic                                  req_tready,
   // [7:0] screen_code, [11:8] color_nibble, [19:12] pattern_byte, [23:20] 0
   input  wire logic [tbcpg_pkg::REQ_WIDTH-1:0]       req_tdata,
   // pixel output
   output      logic                                  rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // [31:0] pixel_word
   output      logic [tbcpg_pkg::WORD_WIDTH-1:0]      rsp_tdata,
   // configuration writes
   input  wire logic                                  csr_valid,
   output      logic                                  csr_ready,
   input  wire logic [tbcpg_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  wire logic [tbcpg_pkg::CSR_DAT_WIDTH-1:0]   csr_data
);
   import tbcpg_pkg::*;

   cfg_type  cfg;
   cell_type cell_ff;
   cell_type cell_in;
   logic     cell_vld_ff;
   logic     cell_vld_in;
   logic     rsp_vld_ff;
   logic     rsp_vld_in;
   word_type rsp_word_ff;
   word_type rsp_word_in;
   word_type render_word;
   logic     out_space;
   logic     cell_fire;
   logic     req_fire;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   tbcpg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Result register frees up when empty or being drained this cycle.
   assign out_space  = !rsp_vld_ff || rsp_tready;
   assign cell_fire  = cell_vld_ff && out_space;
   assign req_tready = !cell_vld_ff || out_space;
   assign req_fire   = req_tvalid && req_tready;

   // Unpack the cell fields, drop the pad bits.
   always_comb begin
      cell_in              = cell_ff;
      cell_in.screen_code  = req_tdata[7:0];
      cell_in.color_nibble = req_tdata[11:8];
      cell_in.pattern_byte = req_tdata[19:12];
   end

   // Hold the cell while the result side is stalled; advance otherwise.
   assign cell_vld_in = req_fire || (cell_vld_ff && !out_space);

   tbcpg_render u_render (
      .cfg        (cfg),
      .cur_cell   (cell_ff),
      .pixel_word (render_word)
   );

   // A cell leaving with the display off is dropped without a result.
   always_comb begin
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_word_in = rsp_word_ff;
      if (cell_fire) begin
         rsp_vld_in  = cfg.display_enable;
         rsp_word_in = render_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         cell_vld_ff <= cell_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cell_ff <= cell_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_word_ff;

   // A cell leaving with display on shows up next cycle with its render.
   `TBCPG_ASSERT_NEXT(a_render_lands, clock, reset, cell_fire && cfg.display_enable, rsp_vld_ff && rsp_word_ff == $past(render_word), "rendered cell did not land in result register")
   // Display off drops the cell.
   `TBCPG_ASSERT_NEXT(a_drop_when_off, clock, reset, cell_fire && !cfg.display_enable, !rsp_vld_ff, "result produced with display off")
   // No result appears from an empty pipeline.
   `TBCPG_ASSERT_NEXT(a_no_invented, clock, reset, !cell_vld_ff && !rsp_vld_ff, !rsp_vld_ff, "result appeared without a cell")
   // The input side only stalls when both stages are occupied.
   `TBCPG_ASSERT_SAME(a_stall_full, clock, reset, !req_tready, cell_vld_ff && rsp_vld_ff && !rsp_tready, "input stalled with room in the pipeline")

endmodule

`default_nettype wire

[rtl/tbcpg_csr.sv]
// -----------------------------------------------------------------------------
// tbcpg_csr
// Mode and background color registers, written over the csr channel.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tbcpg_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_valid,
   input  wire logic [tbcpg_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  wire logic [tbcpg_pkg::CSR_DAT_WIDTH-1:0]   csr_data,
   output tbcpg_pkg::cfg_type                         cfg
);
   import tbcpg_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_DISPLAY_ENABLE: cfg_in.display_enable      = csr_data[0];
            CSR_EXTENDED_COLOR: cfg_in.extended_color_mode = csr_data[0];
            CSR_BITMAP_MODE:    cfg_in.bitmap_mode         = csr_data[0];
            CSR_MULTICOLOR:     cfg_in.multicolor_mode     = csr_data[0];
            CSR_BACKGROUND_0:   cfg_in.background_color_0  = csr_data;
            CSR_BACKGROUND_1:   cfg_in.background_color_1  = csr_data;
            CSR_BACKGROUND_2:   cfg_in.background_color_2  = csr_data;
            CSR_BACKGROUND_3:   cfg_in.background_color_3  = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[rtl/tbcpg_render.sv]
// -----------------------------------------------------------------------------
// tbcpg_render
// Mode decode, palette selection and pixel expansion for one cell.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tbcpg_render (
   input  wire tbcpg_pkg::cfg_type   cfg,
   input  wire tbcpg_pkg::cell_type  cur_cell,
   output tbcpg_pkg::word_type       pixel_word
);
   import tbcpg_pkg::*;

   logic      multi;
   color_type fg;
   color_type bg;
   color_type pal [4];
   color_type bgs [4];
   color_type hi;
   color_type lo;

   assign hi = cur_cell.screen_code[CODE_WIDTH-1 -: PIXEL_WIDTH];
   assign lo = cur_cell.screen_code[PIXEL_WIDTH-1:0];

   assign bgs[0] = cfg.background_color_0;
   assign bgs[1] = cfg.background_color_1;
   assign bgs[2] = cfg.background_color_2;
   assign bgs[3] = cfg.background_color_3;

   // Pick hires or pair rendering and its colors.
   always_comb begin
      multi  = 1'b0;
      fg     = cur_cell.color_nibble;
      bg     = cfg.background_color_0;
      pal[0] = cfg.background_color_0;
      pal[1] = cfg.background_color_1;
      pal[2] = cfg.background_color_2;
      pal[3] = cur_cell.color_nibble;
      priority if (!cfg.bitmap_mode && cfg.extended_color_mode) begin
         bg = bgs[cur_cell.screen_code[CODE_WIDTH-1 -: 2]];
      end else if (!cfg.bitmap_mode) begin
         // pair mode only for cells whose color has bit 3 set
         multi = cfg.multicolor_mode && cur_cell.color_nibble[PIXEL_WIDTH-1];
      end else if (cfg.multicolor_mode) begin
         multi  = 1'b1;
         pal[1] = hi;
         pal[2] = lo;
      end else begin
         fg = hi;
         bg = lo;
      end
   end

   // Expand: pixel p sits at bits 4p+3..4p, pattern bit 7 leftmost.
   always_comb begin
      pixel_word = '0;
      for (int p = 0; p < PIXEL_COUNT; p++) begin
         if (multi) begin
            pixel_word[p*PIXEL_WIDTH +: PIXEL_WIDTH] =
               pal[cur_cell.pattern_byte[(p >> 1)*2 +: 2]];
         end else begin
            pixel_word[p*PIXEL_WIDTH +: PIXEL_WIDTH] =
               cur_cell.pattern_byte[p] ? fg : bg;
         end
      end
   end

endmodule

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the character cell pixel generator
// Sends character cells over the req stream and computes the expected eight
// pixel colors of each cell taken with display on from a local copy of the mode
// registers. Each phase writes all mode registers while the block is idle.
// The phases cover every text and bitmap mode, display off, the mode
// overlaps and extreme background colors. Both stream sides idle at random,
// and one phase holds rsp_tready low long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_top;
   import tbcpg_pkg::*;

   // Cycles to let the two-stage pipe empty when no result is expected.
   localparam int SETTLE_CYCLES  = 6;
   // Length of the receiver hold-off in the pressure phase.
   localparam int HOLD_CYCLES    = 200;
   localparam int RANDOM_PHASES  = 12;
   localparam int CELLS_PER_PASS = 112;
   // Phase roles within the random part.
   localparam int PHASE_ALL_15   = 0;
   localparam int PHASE_ALL_0    = 1;
   localparam int PHASE_PRESSURE = 3;
   localparam int PHASE_STEADY   = 6;
   localparam int PHASE_DARK     = 9;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_WIDTH-1:0]      req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [WORD_WIDTH-1:0]     rsp_tdata;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_WIDTH-1:0]  csr_index = '0;
   logic [CSR_DAT_WIDTH-1:0]  csr_data = '0;

   // Mirror of the mode registers, updated on each accepted register write.
   cfg_type     mode_regs = '0;
   // Cells waiting to be offered, and the one currently on the bus.
   cell_type    cell_queue[$];
   cell_type    offered_cell;
   // Pixel words the block still owes, oldest first.
   word_type    pixel_queue[$];
   int unsigned mismatch_count = 0;
   // Pacing controls set by the stimulus and hold-off processes.
   bit          steady = 1'b0;
   bit          pressure_go = 1'b0;
   logic        hold_off = 1'b0;

   text_bitmap_cell_pixel_generator_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] screen_code, [11:8] color_nibble,
                                 // [19:12] pattern_byte, [23:20] zero
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [31:0] pixel_word
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin : clock_gen
      forever #2 clock = ~clock;
   end

   // Idles with a chance of 8 in 100, never while the steady phase runs.
   function automatic bit take_idle();
      return !steady && ($urandom_range(99) < 8);
   endfunction

   // Render one cell into eight 4-bit colors under the given mode registers.
   function automatic word_type render_cell(input cfg_type m, input cell_type c);
      color_type palette[4];
      color_type fg;
      color_type bg;
      bit        pairs;
      word_type  w;
      fg    = c.color_nibble;
      bg    = m.background_color_0;
      pairs = 1'b0;
      palette[0] = m.background_color_0;
      palette[1] = m.background_color_1;
      palette[2] = m.background_color_2;
      palette[3] = c.color_nibble;
      if (!m.bitmap_mode) begin
         // Extended color wins over multicolor in text mode.
         if (m.extended_color_mode) begin
            case (c.screen_code[7:6])
               2'd0: bg = m.background_color_0;
               2'd1: bg = m.background_color_1;
               2'd2: bg = m.background_color_2;
               default: bg = m.background_color_3;
            endcase
         end else if (m.multicolor_mode && c.color_nibble[3]) begin
            pairs = 1'b1;
         end
      end else if (m.multicolor_mode) begin
         pairs = 1'b1;
         palette[1] = c.screen_code[7:4];
         palette[2] = c.screen_code[3:0];
      end else begin
         fg = c.screen_code[7:4];
         bg = c.screen_code[3:0];
      end
      // Pixel k sits in bits 4k+3..4k and follows pattern bit k, or the bit pair holding bit k in pair mode.
      for (int k = 0; k < PIXEL_COUNT; k++) begin
         if (pairs)
            w[4*k +: 4] = palette[c.pattern_byte[(k/2)*2 +: 2]];
         else
            w[4*k +: 4] = c.pattern_byte[k] ? fg : bg;
      end
      return w;
   endfunction

   // Driver: hold the offered cell until accepted, then advance from the queue.
   // On acceptance, predict the pixels, or nothing with the display off.
   always @(posedge clock) begin : cell_driver
      logic offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         offer = req_tvalid;
         if (req_tvalid && req_tready) begin
            if (mode_regs.display_enable)
               pixel_queue.push_back(render_cell(mode_regs, offered_cell));
            offer = 1'b0;
         end
         if (!offer && cell_queue.size() != 0 && !take_idle()) begin
            offered_cell = cell_queue.pop_front();
            req_tdata <= {4'b0000, offered_cell.pattern_byte,
                          offered_cell.color_nibble, offered_cell.screen_code};
            offer = 1'b1;
         end
         req_tvalid <= offer;
      end
   end

   // Monitor: compare each accepted pixel word with the oldest prediction.
   always @(posedge clock) begin : pixel_monitor
      word_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pixel_queue.size() == 0) begin
               $error("pixel_word unexpected: expected none, actual %h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = pixel_queue.pop_front();
               if (rsp_tdata !== want) begin
                  $error("pixel_word mismatch: expected %h, actual %h", want, rsp_tdata);
                  mismatch_count++;
               end
            end
         end
         rsp_tready <= !hold_off && !take_idle();
      end
   end

   // Receiver hold-off: drop rsp_tready for a long stretch once the pressure
   // phase starts, so the block fills and stalls req_tready.
   initial begin : rsp_hold
      wait (pressure_go);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Write one register and update the mirror once the transaction completes.
   task automatic write_reg(input csr_index_type idx, input logic [3:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      // One-bit registers keep only bit 0 of the data.
      case (idx)
         CSR_DISPLAY_ENABLE: mode_regs.display_enable      = val[0];
         CSR_EXTENDED_COLOR: mode_regs.extended_color_mode = val[0];
         CSR_BITMAP_MODE:    mode_regs.bitmap_mode         = val[0];
         CSR_MULTICOLOR:     mode_regs.multicolor_mode     = val[0];
         CSR_BACKGROUND_0:   mode_regs.background_color_0  = val;
         CSR_BACKGROUND_1:   mode_regs.background_color_1  = val;
         CSR_BACKGROUND_2:   mode_regs.background_color_2  = val;
         default:            mode_regs.background_color_3  = val;
      endcase
   endtask

   // Program all mode registers; flag bits get random junk in the upper bits.
   task automatic set_modes(input logic [3:0] flags, input color_type b0,
                            input color_type b1, input color_type b2,
                            input color_type b3);
      write_reg(CSR_DISPLAY_ENABLE, {3'($urandom_range(7)), flags[3]});
      write_reg(CSR_EXTENDED_COLOR, {3'($urandom_range(7)), flags[2]});
      write_reg(CSR_BITMAP_MODE,    {3'($urandom_range(7)), flags[1]});
      write_reg(CSR_MULTICOLOR,     {3'($urandom_range(7)), flags[0]});
      write_reg(CSR_BACKGROUND_0, b0);
      write_reg(CSR_BACKGROUND_1, b1);
      write_reg(CSR_BACKGROUND_2, b2);
      write_reg(CSR_BACKGROUND_3, b3);
   endtask

   // Wait until every cell is accepted and every pixel word has come back,
   // then let the pipe empty of cells that produce nothing.
   task automatic drain();
      do @(posedge clock);
      while (cell_queue.size() != 0 || req_tvalid || pixel_queue.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic push_cell(input code_type scr, input color_type col,
                            input pattern_type pat);
      cell_type c;
      c.screen_code  = scr;
      c.color_nibble = col;
      c.pattern_byte = pat;
      cell_queue.push_back(c);
   endtask

   initial begin : stimulus
      // Directed mode flags {display, extended, bitmap, multicolor}:
      // standard text, extended text, multicolor text, standard bitmap,
      // multicolor bitmap, extended over multicolor text, extended ignored
      // in bitmap, and display off with modes set.
      logic [3:0] directed_modes[8];
      logic [3:0] flags;
      color_type  bgs[4];
      directed_modes = '{4'b1000, 4'b1100, 4'b1001, 4'b1010,
                         4'b1011, 4'b1101, 4'b1111, 4'b0101};

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: distinct backgrounds so every color source is visible.
      // Cells hit all bit pairs, an all-ones pattern and color bit 3 both ways.
      foreach (directed_modes[i]) begin
         set_modes(directed_modes[i], 4'h1, 4'h2, 4'h3, 4'h4);
         push_cell(8'hFF, 4'hF, 8'h1B);
         push_cell(8'h00, 4'h0, 8'hFF);
         push_cell(8'h4A, 4'h8, 8'hE4);
         drain();
      end

      // Random: the first eight phases walk all mode combinations, the rest
      // pick modes at random. One phase runs dark, one has no idling, and one
      // carries the long receiver hold-off.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         flags = (p < 8) ? {1'b1, 3'(p)} : {1'b1, 3'($urandom_range(7))};
         if (p == PHASE_DARK)
            flags[3] = 1'b0;
         foreach (bgs[j]) begin
            if (p == PHASE_ALL_15)
               bgs[j] = 4'hF;
            else if (p == PHASE_ALL_0)
               bgs[j] = 4'h0;
            else
               bgs[j] = 4'($urandom_range(15));
         end
         set_modes(flags, bgs[0], bgs[1], bgs[2], bgs[3]);
         steady = (p == PHASE_STEADY);
         for (int n = 0; n < CELLS_PER_PASS; n++)
            push_cell(8'($urandom_range(255)), 4'($urandom_range(15)),
                      8'($urandom_range(255)));
         if (p == PHASE_PRESSURE)
            pressure_go = 1'b1;
         drain();
      end

      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Run limit, far beyond the slowest correct run.
   initial begin : run_limit
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

[text_bitmap_cell_pixel_generator_top.f]
+incdir+rtl
rtl/tbcpg_pkg.sv
rtl/tbcpg_csr.sv
rtl/tbcpg_render.sv
rtl/text_bitmap_cell_pixel_generator_top.sv
test/tb_top.sv
